// File: design/sv39pmb_pkg.sv
package sv39pmb_pkg;

    // Field widths
    localparam int VA_W     = 27;
    localparam int PPN_W    = 44;
    localparam int PERM_W   = 4;
    localparam int ADDR_W   = 56;
    localparam int ENTRY_W  = 54;
    localparam int IDX_W    = 9;
    localparam int ADDED_W  = 2;

    // Table geometry
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int POOL_PAGES_DEF    = 64;

    localparam logic [PPN_W-1:0] BASE_RESET = 44'h000_0008_0000;

    typedef struct packed {
        logic [VA_W-1:0]   virtual_page;
        logic [PPN_W-1:0]  physical_page;
        logic [PERM_W-1:0] permissions;
    } req_t;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] entry_address;
        logic [ENTRY_W-1:0] entry_value;
        logic [ADDED_W-1:0] tables_added;
    } rsp_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;     // capture request
        logic rd_root;    // read root[vpn2]
        logic rd_mid;     // read level-1 table[vpn1]
        logic ev_root;    // follow root entry
        logic ev_mid;     // follow level-1 entry
        logic check;      // pool capacity check
        logic clr;        // zero one entry of the page being cleared
        logic clr_root;   // clear targets page 0 (post-reset pass)
        logic link_top;   // write root pointer to new page
        logic link_mid;   // write level-1 pointer to new page
        logic wr_leaf;    // write leaf entry
        logic load_out;   // load result register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic       hit;       // entry valid and inside allocated pool
        logic       clr_last;  // last entry of page clear
        logic [1:0] need;      // pages still to allocate
        logic       fail;      // pool would overflow
    } sts_t;

endpackage

// File: design/sv39pmb_ctrl.sv
module sv39pmb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  sv39pmb_pkg::sts_t  sts,
    output sv39pmb_pkg::cmd_t  cmd
);

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD2   = 4'd2;
    localparam logic [3:0] ST_EV2   = 4'd3;
    localparam logic [3:0] ST_RD1   = 4'd4;
    localparam logic [3:0] ST_EV1   = 4'd5;
    localparam logic [3:0] ST_CHK   = 4'd6;
    localparam logic [3:0] ST_CLR1  = 4'd7;
    localparam logic [3:0] ST_LINK1 = 4'd8;
    localparam logic [3:0] ST_CLR0  = 4'd9;
    localparam logic [3:0] ST_LINK0 = 4'd10;
    localparam logic [3:0] ST_LEAF  = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.clr      = 1'b1;
                cmd.clr_root = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_RD2;
                end
            end
            ST_RD2: begin
                cmd.rd_root = 1'b1;
                state_next  = ST_EV2;
            end
            ST_EV2: begin
                cmd.ev_root = 1'b1;
                state_next  = sts.hit ? ST_RD1 : ST_CHK;
            end
            ST_RD1: begin
                cmd.rd_mid = 1'b1;
                state_next = ST_EV1;
            end
            ST_EV1: begin
                cmd.ev_mid = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cmd.check = 1'b1;
                if (sts.fail) begin
                    state_next = ST_DONE;
                end else if (sts.need == 2'd2) begin
                    state_next = ST_CLR1;
                end else if (sts.need == 2'd1) begin
                    state_next = ST_CLR0;
                end else begin
                    state_next = ST_LEAF;
                end
            end
            ST_CLR1: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_LINK1;
                end
            end
            ST_LINK1: begin
                cmd.link_top = 1'b1;
                state_next   = ST_CLR0;
            end
            ST_CLR0: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_LINK0;
                end
            end
            ST_LINK0: begin
                cmd.link_mid = 1'b1;
                state_next   = ST_LEAF;
            end
            ST_LEAF: begin
                cmd.wr_leaf = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: design/sv39pmb_dpath.sv
module sv39pmb_dpath #(
    parameter int POOL_PAGES = sv39pmb_pkg::POOL_PAGES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [sv39pmb_pkg::PPN_W-1:0]        cfg_wdata,
    input  sv39pmb_pkg::req_t                    s_data,
    input  sv39pmb_pkg::cmd_t                    cmd,
    output sv39pmb_pkg::sts_t                    sts,
    output sv39pmb_pkg::rsp_t                    m_data
);

    localparam int PPN_W = sv39pmb_pkg::PPN_W;
    localparam int IDX_W = sv39pmb_pkg::IDX_W;
    localparam int ENT_W = sv39pmb_pkg::ENTRY_W;
    localparam int PW    = $clog2(POOL_PAGES);
    localparam int CW    = $clog2(POOL_PAGES + 1);
    localparam int AW    = PW + IDX_W;
    localparam int DEPTH = POOL_PAGES * sv39pmb_pkg::ENTRIES_PER_TABLE;

    logic [ENT_W-1:0] mem [DEPTH];

    sv39pmb_pkg::req_t req_reg;
    sv39pmb_pkg::rsp_t out_reg;
    logic [PPN_W-1:0]  base_reg;
    logic [CW-1:0]     nfp_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [PW-1:0]     page1_reg, page0_reg;
    logic [1:0]        need_reg;
    logic [1:0]        added_reg;
    logic              fail_reg;
    logic [ENT_W-1:0]  rd_data_reg;

    logic [IDX_W-1:0]  vpn2, vpn1, vpn0;
    logic [PPN_W-1:0]  off;
    logic              hit;
    logic              fail;
    logic [PW-1:0]     new_page;
    logic [PPN_W-1:0]  new_ppn, leaf_ppn;
    logic              we, re;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [ENT_W-1:0]  wr_data, leaf_val;

    assign vpn2 = req_reg.virtual_page[3*IDX_W-1:2*IDX_W];
    assign vpn1 = req_reg.virtual_page[2*IDX_W-1:IDX_W];
    assign vpn0 = req_reg.virtual_page[IDX_W-1:0];

    // Follow check: valid bit set and target lies among allocated pages
    assign off  = rd_data_reg[ENT_W-1:10] - base_reg;
    assign hit  = rd_data_reg[0] && (off < PPN_W'(nfp_reg));
    assign fail = ({1'b0, nfp_reg} + (CW+1)'(need_reg)) > (CW+1)'(POOL_PAGES);

    assign new_page = nfp_reg[PW-1:0];
    assign new_ppn  = base_reg + PPN_W'(new_page);
    assign leaf_ppn = base_reg + PPN_W'(page0_reg);
    assign leaf_val = {req_reg.physical_page, 5'b0, req_reg.permissions, 1'b1};

    always_comb begin
        we      = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.clr) begin
            we      = 1'b1;
            wr_addr = {(cmd.clr_root ? {PW{1'b0}} : new_page), clr_cnt_reg};
        end else if (cmd.link_top) begin
            we      = 1'b1;
            wr_addr = {{PW{1'b0}}, vpn2};
            wr_data = {new_ppn, 9'b0, 1'b1};
        end else if (cmd.link_mid) begin
            we      = 1'b1;
            wr_addr = {page1_reg, vpn1};
            wr_data = {new_ppn, 9'b0, 1'b1};
        end else if (cmd.wr_leaf) begin
            we      = 1'b1;
            wr_addr = {page0_reg, vpn0};
            wr_data = leaf_val;
        end
    end

    assign re      = cmd.rd_root || cmd.rd_mid;
    assign rd_addr = cmd.rd_root ? {{PW{1'b0}}, vpn2} : {page1_reg, vpn1};

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= sv39pmb_pkg::BASE_RESET;
            nfp_reg     <= CW'(1);
            clr_cnt_reg <= '0;
            added_reg   <= '0;
            fail_reg    <= 1'b0;
            need_reg    <= '0;
        end else begin
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
            if (cmd.clr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.accept) begin
                added_reg <= '0;
                fail_reg  <= 1'b0;
            end
            if (cmd.ev_root) begin
                need_reg <= hit ? 2'd0 : 2'd2;
            end
            if (cmd.ev_mid) begin
                need_reg <= hit ? 2'd0 : 2'd1;
            end
            if (cmd.check) begin
                fail_reg <= fail;
            end
            if (cmd.link_top || cmd.link_mid) begin
                nfp_reg   <= nfp_reg + 1'b1;
                added_reg <= added_reg + 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg <= s_data;
        end
        if (cmd.ev_root) begin
            page1_reg <= off[PW-1:0];
        end
        if (cmd.ev_mid) begin
            page0_reg <= off[PW-1:0];
        end
        if (cmd.link_top) begin
            page1_reg <= new_page;
        end
        if (cmd.link_mid) begin
            page0_reg <= new_page;
        end
        if (cmd.load_out) begin
            if (fail_reg) begin
                out_reg.status        <= 1'b1;
                out_reg.entry_address <= '0;
                out_reg.entry_value   <= '0;
                out_reg.tables_added  <= '0;
            end else begin
                out_reg.status        <= 1'b0;
                out_reg.entry_address <= {leaf_ppn, vpn0, 3'b0};
                out_reg.entry_value   <= leaf_val;
                out_reg.tables_added  <= added_reg;
            end
        end
    end

    assign sts.hit      = hit;
    assign sts.clr_last = (clr_cnt_reg == {IDX_W{1'b1}});
    assign sts.need     = need_reg;
    assign sts.fail     = fail;
    assign m_data       = out_reg;

endmodule

// File: design/sv39_page_mapping_builder_unit.sv
// Channel  Dir  Ports                          Moves
// -------  ---  -----------------------------  -------------------------------------
// s_       in   s_valid s_ready s_data         request: virtual page, phys page, perms
// m_       out  m_valid m_ready m_data         result: status, entry addr/value, count
// cfg_     in   cfg_we cfg_wdata               pool base page number (write only)
//
// Flow: when both upper levels already hit, no table is added; each new table adds a
//   clear of all 512 of its entries plus one link write, and when two new tables are
//   needed the level-1 read is skipped. The table memory (one read or write per cycle)
//   and the page clear loop set the length of a request.
// Reset: sync, active low; afterwards all 512 entries of pool page 0 (root) are zeroed
//   with s_ready low. Config writes are taken during that pass.
// Stalls: one request at a time; the next is taken while a result waits in the
//   output register, and m_ready low only holds the block at its final step.
module sv39_page_mapping_builder_unit #(
    parameter int POOL_PAGES = sv39pmb_pkg::POOL_PAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [sv39pmb_pkg::PPN_W-1:0] cfg_wdata,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sv39pmb_pkg::req_t             s_data,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output sv39pmb_pkg::rsp_t             m_data
);

    sv39pmb_pkg::cmd_t cmd;
    sv39pmb_pkg::sts_t sts;

    // Sequencer: post-reset root clear, walk, capacity check, clear/link of new tables, leaf write, result load
    sv39pmb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table memory, allocator, base register and result register
    sv39pmb_dpath #(
        .POOL_PAGES (POOL_PAGES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

    // One request in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // Exhausted results carry no entry
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |->
            (m_data.entry_value == '0) && (m_data.entry_address == '0) &&
            (m_data.tables_added == '0))
        else $error("exhausted result carries nonzero fields");

    // Mapped results hold a valid leaf and at most two new tables
    a_leaf_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.status |->
            m_data.entry_value[0] && (m_data.tables_added != 2'd3))
        else $error("malformed mapped result");

    // A new result is loaded only when the output register is free or drains
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result overwritten before it was taken");

endmodule
